// ===== rtl/core/cqce_pkg.sv =====
// Shared types, widths and constants of the conjunctive query count engine.
// Used by the channel interfaces and by every module of the engine.
package cqce_pkg;

   // Fixed field widths of the request and response beats.
   localparam int ROW_IDX_W  = 10;
   localparam int ATTR_IDX_W = 4;
   localparam int VALUE_W    = 20;
   localparam int CODE_W     = 3;
   localparam int COUNT_W    = 11;
   localparam int HASH_W     = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_RECORDS_IN_USE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPRESS_THRESHOLD = 1'd1;

   // Defaults of the top-level parameters.
   localparam int DEF_MAX_RECORDS = 1024;
   localparam int DEF_NUM_ATTRS   = 16;
   localparam int DEF_VALUE_BITS  = 20;

   // Request command codes.
   localparam logic CMD_CELL_WRITE = 1'b0;
   localparam logic CMD_QUERY_TERM = 1'b1;

   // Comparison codes of a query term (stored cell OP term value).
   localparam logic signed [CODE_W-1:0] CMP_NONE = 3'sd0;
   localparam logic signed [CODE_W-1:0] CMP_EQ   = 3'sd1;
   localparam logic signed [CODE_W-1:0] CMP_NE   = -3'sd1;
   localparam logic signed [CODE_W-1:0] CMP_GT   = 3'sd2;
   localparam logic signed [CODE_W-1:0] CMP_GE   = 3'sd3;
   localparam logic signed [CODE_W-1:0] CMP_LT   = -3'sd2;
   localparam logic signed [CODE_W-1:0] CMP_LE   = -3'sd3;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [HASH_W-1:0] HASH_MUL = 32'h045d9f3b;
   localparam int HASH_SHIFT = 16;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_TERM,
      OP_SCAN
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic                       term_en;
      logic [ROW_IDX_W-1:0]       row_index;
      logic [ATTR_IDX_W-1:0]      attr_index;
      logic [VALUE_W-1:0]         value;
      logic signed [CODE_W-1:0]   code;
   } cmd_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_DONE
   } bk_state_type;

   // One round of the row hash: xor-shift, then a multiply mod 2^32.
   function automatic logic [HASH_W-1:0] mix_round(input logic [HASH_W-1:0] y);
      logic [HASH_W-1:0] folded;
      folded = (y >> HASH_SHIFT) ^ y;
      return folded * HASH_MUL;
   endfunction

endpackage

// ===== rtl/core/cqce_if.sv =====
// Valid/ready channel interfaces of the conjunctive query count engine.
// Depends on cqce_pkg for the payload widths.
interface cqce_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      cmd;
   logic [cqce_pkg::ROW_IDX_W-1:0]            row_index;
   logic [cqce_pkg::ATTR_IDX_W-1:0]           attr_index;
   logic [cqce_pkg::VALUE_W-1:0]              cell_or_term_value;
   logic signed [cqce_pkg::CODE_W-1:0]        compare_code;
   logic                                      last_term;

   modport source (
      output valid, cmd, row_index, attr_index, cell_or_term_value, compare_code,
             last_term,
      input  ready
   );
   modport sink (
      input  valid, cmd, row_index, attr_index, cell_or_term_value, compare_code,
             last_term,
      output ready
   );
endinterface

interface cqce_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [cqce_pkg::COUNT_W-1:0]              match_count;
   logic [cqce_pkg::HASH_W-1:0]               set_hash;
   logic                                      suppressed;

   modport source (
      output valid, match_count, set_hash, suppressed,
      input  ready
   );
   modport sink (
      input  valid, match_count, set_hash, suppressed,
      output ready
   );
endinterface

// ===== rtl/core/cqce_front.sv =====
// Front end: accepts request beats and classifies them into queue commands.
// Depends on cqce_pkg and cqce_req_if.
module cqce_front #(
   parameter int MAX_RECORDS = cqce_pkg::DEF_MAX_RECORDS,
   parameter int NUM_ATTRS   = cqce_pkg::DEF_NUM_ATTRS
) (
   cqce_req_if.sink                req_chan,
   input  logic                    q_full,
   output logic                    push,
   output cqce_pkg::cmd_entry_type push_entry
);
   import cqce_pkg::*;

   logic row_ok;
   logic attr_ok;
   logic accept;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   always_comb begin
      row_ok  = 32'(req_chan.row_index) < MAX_RECORDS;
      attr_ok = 32'(req_chan.attr_index) < NUM_ATTRS;

      push_entry.row_index  = req_chan.row_index;
      push_entry.attr_index = req_chan.attr_index;
      push_entry.value      = req_chan.cell_or_term_value;
      push_entry.code       = req_chan.compare_code;
      push_entry.term_en    = attr_ok;
      push_entry.op         = OP_WRITE;
      push                  = 1'b0;

      // Beats that would change nothing are taken and dropped here.
      if (req_chan.cmd == CMD_CELL_WRITE) begin
         push_entry.op = OP_WRITE;
         push          = accept && row_ok && attr_ok;
      end else if (req_chan.last_term) begin
         push_entry.op = OP_SCAN;
         push          = accept;
      end else begin
         push_entry.op = OP_TERM;
         push          = accept && attr_ok;
      end
   end

endmodule

// ===== rtl/core/cqce_cmd_queue.sv =====
// Short command queue between the front end and the scan back end.
// Depends on cqce_pkg for the entry type and the depth.
module cqce_cmd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  cqce_pkg::cmd_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output cqce_pkg::cmd_entry_type pop_entry,
   output logic                    empty
);
   import cqce_pkg::*;

   cmd_entry_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QFILL_W-1:0]   fill_ff;
   logic [QFILL_W-1:0]   fill_in;

   assign full      = fill_ff == QFILL_W'(QUEUE_DEPTH);
   assign empty     = fill_ff == '0;
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/cqce_back.sv =====
// Back end: executes cell writes and term stores, and runs the pipelined row scan.
// Depends on cqce_pkg and cqce_rsp_if; holds the table as one memory per attribute.
module cqce_back #(
   parameter int MAX_RECORDS = cqce_pkg::DEF_MAX_RECORDS,
   parameter int NUM_ATTRS   = cqce_pkg::DEF_NUM_ATTRS,
   parameter int VALUE_BITS  = cqce_pkg::DEF_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cqce_pkg::cmd_entry_type           q_entry,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  logic [cqce_pkg::CSR_DATA_W-1:0]   records_in_use,
   input  logic [cqce_pkg::CSR_DATA_W-1:0]   suppress_threshold,
   cqce_rsp_if.source                        rsp_chan
);
   import cqce_pkg::*;

   localparam int STORE_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
   localparam int ROW_W   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int CNT_W   = $clog2(MAX_RECORDS + 1);

   function automatic logic term_holds(input logic signed [CODE_W-1:0] code,
                                       input logic [STORE_W-1:0] cell_value,
                                       input logic [STORE_W-1:0] ref_value);
      logic ok;
      case (code)
         CMP_EQ:  ok = cell_value == ref_value;
         CMP_NE:  ok = cell_value != ref_value;
         CMP_GT:  ok = cell_value > ref_value;
         CMP_GE:  ok = cell_value >= ref_value;
         CMP_LT:  ok = cell_value < ref_value;
         CMP_LE:  ok = cell_value <= ref_value;
         default: ok = 1'b1;
      endcase
      return ok;
   endfunction

   bk_state_type          state_ff, state_in;
   logic [CNT_W-1:0]      row_ff, row_in;
   logic [CNT_W-1:0]      limit_ff, limit_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [HASH_W-1:0]     hash_ff, hash_in;
   logic [CNT_W-1:0]      scan_rows;
   logic                  rd_en;
   logic                  load_rsp;
   logic                  clear_terms;
   logic                  term_wr;

   // Scan pipeline: memory read, compare and first hash round, second round.
   logic                  v1_ff, v2_ff, v3_ff;
   logic [HASH_W-1:0]     x1_ff;
   logic                  m2_ff, m3_ff;
   logic [HASH_W-1:0]     p2_ff, p3_ff;
   logic [NUM_ATTRS-1:0]  lane_ok;

   logic                  rsp_valid_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [HASH_W-1:0]     rsp_hash_ff;
   logic                  rsp_supp_ff;

   assign q_pop   = (state_ff == BK_IDLE) && !q_empty;
   assign term_wr = q_pop && ((q_entry.op == OP_TERM) ||
                              ((q_entry.op == OP_SCAN) && q_entry.term_en));

   always_comb begin
      if (32'(records_in_use) > MAX_RECORDS) begin
         scan_rows = CNT_W'(MAX_RECORDS);
      end else begin
         scan_rows = CNT_W'(records_in_use);
      end
   end

   for (genvar lane = 0; lane < NUM_ATTRS; lane++) begin : g_lane
      logic [STORE_W-1:0]         mem [MAX_RECORDS];
      logic [STORE_W-1:0]         rd_data_ff;
      logic [STORE_W-1:0]         term_val_ff;
      logic signed [CODE_W-1:0]   term_code_ff;
      logic                       lane_sel;

      assign lane_sel = 32'(q_entry.attr_index) == lane;

      always_ff @(posedge clock) begin
         if (q_pop && (q_entry.op == OP_WRITE) && lane_sel) begin
            mem[ROW_W'(q_entry.row_index)] <= STORE_W'(q_entry.value);
         end
         if (rd_en) begin
            rd_data_ff <= mem[row_ff[ROW_W-1:0]];
         end
      end

      always_ff @(posedge clock) begin
         if (reset || clear_terms) begin
            term_val_ff  <= '0;
            term_code_ff <= CMP_NONE;
         end else if (term_wr && lane_sel) begin
            term_val_ff  <= STORE_W'(q_entry.value);
            term_code_ff <= q_entry.code;
         end
      end

      assign lane_ok[lane] = term_holds(term_code_ff, rd_data_ff, term_val_ff);
   end

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      limit_in    = limit_ff;
      rd_en       = 1'b0;
      load_rsp    = 1'b0;
      clear_terms = 1'b0;

      count_in = count_ff;
      hash_in  = hash_ff;
      if (v3_ff && m3_ff) begin
         count_in = count_ff + 1'b1;
         hash_in  = hash_ff ^ p3_ff ^ (p3_ff >> HASH_SHIFT);
      end

      case (state_ff)
         BK_IDLE: begin
            if (q_pop && (q_entry.op == OP_SCAN)) begin
               row_in   = '0;
               limit_in = scan_rows;
               count_in = '0;
               hash_in  = '0;
               state_in = (scan_rows == '0) ? BK_DRAIN : BK_SCAN;
            end
         end
         BK_SCAN: begin
            rd_en  = 1'b1;
            row_in = row_ff + 1'b1;
            if (row_ff + 1'b1 == limit_ff) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp    = 1'b1;
               clear_terms = 1'b1;
               state_in    = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= rd_en;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      limit_ff <= limit_in;
      count_ff <= count_in;
      hash_ff  <= hash_in;
      x1_ff    <= 32'(row_ff) + 32'd1;
      m2_ff    <= &lane_ok;
      p2_ff    <= mix_round(x1_ff);
      m3_ff    <= m2_ff;
      p3_ff    <= mix_round(p2_ff);
      if (load_rsp) begin
         rsp_count_ff <= COUNT_W'(count_ff);
         rsp_hash_ff  <= hash_ff;
         rsp_supp_ff  <= 32'(count_ff) <= 32'(suppress_threshold);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_count = rsp_count_ff;
   assign rsp_chan.set_hash    = rsp_hash_ff;
   assign rsp_chan.suppressed  = rsp_supp_ff;

endmodule

// ===== rtl/core/conjunctive_query_count_engine.sv =====
// Channel        | Dir | Beat carries
// req_chan       | in  | cell write or query term (cmd, row, attr, value, code, last)
// rsp_chan       | out | match_count, set_hash, suppressed, one per last term
// csr_*          | in  | records_in_use (index 0), suppress_threshold (index 1)
//
// Cell writes and plain terms drain from the command queue at one per cycle while no query is being scanned.
// A last term scans records_in_use (saturated to MAX_RECORDS) table rows, none when
// no record is in use: one table row per cycle through the per-attribute memories, then
// the three-stage compare and hash pipeline drains and the result is loaded into the
// output register.
// Reset clears the queue, the terms and the registers; the table holds no reset value.
// A stalled response holds the back end only once the next query result is ready.
//
// Top level of the conjunctive query count engine; depends on cqce_pkg,
// cqce_if, cqce_front, cqce_cmd_queue and cqce_back.
module conjunctive_query_count_engine #(
   parameter int MAX_RECORDS = cqce_pkg::DEF_MAX_RECORDS,
   parameter int NUM_ATTRS   = cqce_pkg::DEF_NUM_ATTRS,
   parameter int VALUE_BITS  = cqce_pkg::DEF_VALUE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   cqce_req_if.sink                         req_chan,
   cqce_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [cqce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cqce_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cqce_pkg::*;

   logic [CSR_DATA_W-1:0]  records_ff;
   logic [CSR_DATA_W-1:0]  threshold_ff;
   logic                   push;
   cmd_entry_type          push_entry;
   logic                   q_full;
   logic                   q_pop;
   cmd_entry_type          q_entry;
   logic                   q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         records_ff   <= '0;
         threshold_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RECORDS_IN_USE:     records_ff   <= csr_wdata;
            CSR_SUPPRESS_THRESHOLD: threshold_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   cqce_front #(
      .MAX_RECORDS (MAX_RECORDS),
      .NUM_ATTRS   (NUM_ATTRS)
   ) u_front (
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   cqce_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (q_entry),
      .empty      (q_empty)
   );

   cqce_back #(
      .MAX_RECORDS (MAX_RECORDS),
      .NUM_ATTRS   (NUM_ATTRS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_entry            (q_entry),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .records_in_use     (records_ff),
      .suppress_threshold (threshold_ff),
      .rsp_chan           (rsp_chan)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the conjunctive query count engine: loads the record table,
// runs directed and random counting queries under varied flow control, and checks each
// response beat against a local model. Depends on cqce_pkg, cqce_if and the engine RTL.
`timescale 1ns / 1ps

module tb_top;
   import cqce_pkg::*;

   localparam int ROWS = DEF_MAX_RECORDS;
   localparam int ATTRS = DEF_NUM_ATTRS;
   localparam logic [VALUE_W-1:0] VALUE_TOP = '1;
   localparam logic signed [CODE_W-1:0] CMP_SPARE = 3'sb100;
   localparam logic [HASH_W-1:0] ROW_MIX = 32'h045d9f3b;
   localparam int SETTLE_CYCLES = 32;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [HASH_W-1:0]  hash;
      logic               suppressed;
   } tally_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cqce_req_if req_bus ();
   cqce_rsp_if rsp_bus ();

   conjunctive_query_count_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the engine state.
   logic [VALUE_W-1:0]       table_copy [ROWS][ATTRS];
   logic [VALUE_W-1:0]       bound_copy [ATTRS];
   logic signed [CODE_W-1:0] code_copy [ATTRS];
   logic [CSR_DATA_W-1:0]    records_reg;
   logic [CSR_DATA_W-1:0]    threshold_reg;
   tally_type                expected_tallies [$];

   int rows_ready = 0;
   int beats_sent = 0;
   int error_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [HASH_W-1:0] row_tag(input int unsigned row);
      logic [HASH_W-1:0] x;
      x = HASH_W'(row + 1);
      repeat (2) x = ((x >> 16) ^ x) * ROW_MIX;
      return (x >> 16) ^ x;
   endfunction

   function automatic logic term_passes(input logic signed [CODE_W-1:0] code,
                                        input logic [VALUE_W-1:0] stored,
                                        input logic [VALUE_W-1:0] bound);
      case (code)
         CMP_EQ: return stored == bound;
         CMP_NE: return stored != bound;
         CMP_GT: return stored > bound;
         CMP_GE: return stored >= bound;
         CMP_LT: return stored < bound;
         CMP_LE: return stored <= bound;
         default: return 1'b1;
      endcase
   endfunction

   function automatic tally_type tally_query();
      tally_type t;
      int unsigned n;
      logic hit;
      t = '0;
      n = (records_reg > ROWS) ? ROWS : records_reg;
      for (int r = 0; r < n; r++) begin
         hit = 1'b1;
         for (int a = 0; a < ATTRS; a++)
            if (!term_passes(code_copy[a], table_copy[r][a], bound_copy[a]))
               hit = 1'b0;
         if (hit) begin
            t.count = t.count + 1'b1;
            t.hash = t.hash ^ row_tag(r);
         end
      end
      t.suppressed = (t.count <= threshold_reg);
      return t;
   endfunction

   function automatic void apply_request(input logic cmd, input logic [ROW_IDX_W-1:0] row,
                                         input logic [ATTR_IDX_W-1:0] attr,
                                         input logic [VALUE_W-1:0] value,
                                         input logic signed [CODE_W-1:0] code,
                                         input logic last);
      if (cmd == CMD_CELL_WRITE) begin
         table_copy[row][attr] = value;
         return;
      end
      bound_copy[attr] = value;
      code_copy[attr] = code;
      if (last) begin
         expected_tallies.push_back(tally_query());
         for (int a = 0; a < ATTRS; a++) begin
            bound_copy[a] = '0;
            code_copy[a] = CMP_NONE;
         end
      end
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(9);
      // Mostly a few small values, so that equality terms find matches.
      if (roll < 6) return VALUE_W'($urandom_range(3));
      if (roll == 6) return VALUE_TOP;
      return VALUE_W'($urandom);
   endfunction

   function automatic logic signed [CODE_W-1:0] pick_code();
      return CODE_W'($urandom_range(7));
   endfunction

   function automatic void compare_field(input string field, input logic [HASH_W-1:0] want,
                                         input logic [HASH_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endfunction

   // Valid stays high between back-to-back beats; it drops only for a gap or a pause.
   task automatic send_beat(input logic cmd, input logic [ROW_IDX_W-1:0] row,
                            input logic [ATTR_IDX_W-1:0] attr,
                            input logic [VALUE_W-1:0] value,
                            input logic signed [CODE_W-1:0] code, input logic last);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.row_index <= row;
      req_bus.attr_index <= attr;
      req_bus.cell_or_term_value <= value;
      req_bus.compare_code <= code;
      req_bus.last_term <= last;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      apply_request(cmd, row, attr, value, code, last);
   endtask

   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (expected_tallies.size() != 0) @(posedge clock);
      // Cell writes and open terms may still be draining from the command queue.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(input int records, input int threshold);
      wait_quiet();
      csr_we <= 1'b1;
      csr_index <= CSR_RECORDS_IN_USE;
      csr_wdata <= CSR_DATA_W'(records);
      @(posedge clock);
      csr_index <= CSR_SUPPRESS_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(threshold);
      @(posedge clock);
      csr_we <= 1'b0;
      records_reg = CSR_DATA_W'(records);
      threshold_reg = CSR_DATA_W'(threshold);
   endtask

   task automatic fill_rows(input int first_row, input int last_row);
      for (int r = first_row; r <= last_row; r++)
         for (int a = 0; a < ATTRS; a++)
            send_beat(CMD_CELL_WRITE, ROW_IDX_W'(r), ATTR_IDX_W'(a), pick_value(),
                      pick_code(), 1'($urandom_range(1)));
      if (first_row <= rows_ready && last_row >= rows_ready) rows_ready = last_row + 1;
   endtask

   task automatic issue_query(input int open_terms);
      repeat (open_terms)
         send_beat(CMD_QUERY_TERM, ROW_IDX_W'($urandom_range(ROWS - 1)),
                   ATTR_IDX_W'($urandom_range(ATTRS - 1)), pick_value(), pick_code(), 1'b0);
      send_beat(CMD_QUERY_TERM, ROW_IDX_W'($urandom_range(ROWS - 1)),
                ATTR_IDX_W'($urandom_range(ATTRS - 1)), pick_value(), pick_code(), 1'b1);
   endtask

   // Right after reset no record is in use, so a query counts nothing.
   task automatic test_empty_table();
      send_beat(CMD_CELL_WRITE, ROW_IDX_W'(ROWS - 1), ATTR_IDX_W'(ATTRS - 1), VALUE_TOP,
                CMP_SPARE, 1'b1);
      send_beat(CMD_QUERY_TERM, 0, 0, '0, CMP_EQ, 1'b1);
   endtask

   task automatic test_comparisons();
      set_registers(16, 3);
      send_beat(CMD_CELL_WRITE, 0, 0, '0, CMP_NONE, 1'b0);
      send_beat(CMD_CELL_WRITE, 1, 0, VALUE_TOP, CMP_NONE, 1'b0);
      send_beat(CMD_CELL_WRITE, 2, 0, 2, CMP_NONE, 1'b1);
      send_beat(CMD_QUERY_TERM, 0, 0, '0, CMP_EQ, 1'b1);
      send_beat(CMD_QUERY_TERM, 0, 0, VALUE_TOP, CMP_NE, 1'b1);
      send_beat(CMD_QUERY_TERM, 0, 0, 2, CMP_GT, 1'b1);
      send_beat(CMD_QUERY_TERM, 0, 0, 2, CMP_GE, 1'b1);
      send_beat(CMD_QUERY_TERM, 0, 0, 2, CMP_LT, 1'b1);
      send_beat(CMD_QUERY_TERM, 0, 0, VALUE_TOP, CMP_LE, 1'b1);
      // The unused code places no condition on the attribute.
      send_beat(CMD_QUERY_TERM, 0, ATTR_IDX_W'(ATTRS - 1), VALUE_TOP, CMP_SPARE, 1'b1);
      send_beat(CMD_QUERY_TERM, 0, 3, '0, CMP_NONE, 1'b1);
      // A term without last_term stays in force until the query ends.
      send_beat(CMD_QUERY_TERM, ROW_IDX_W'(ROWS - 1), ATTR_IDX_W'(ATTRS - 1), '0, CMP_GE,
                1'b0);
      send_beat(CMD_QUERY_TERM, 0, 0, VALUE_TOP, CMP_LT, 1'b1);
      // A second term on the same attribute replaces the first.
      send_beat(CMD_QUERY_TERM, 0, 0, VALUE_TOP, CMP_EQ, 1'b0);
      send_beat(CMD_QUERY_TERM, 0, 0, '0, CMP_EQ, 1'b0);
      send_beat(CMD_QUERY_TERM, 0, 1, '0, CMP_NONE, 1'b1);
   endtask

   task automatic test_register_sweep();
      int sweep_rows [6] = '{0, 1, 16, 16, 9, 5};
      int sweep_thr [6] = '{0, 1, 0, 2047, 1024, 2};
      for (int i = 0; i < 6; i++) begin
         set_registers(sweep_rows[i], sweep_thr[i]);
         repeat (3) issue_query($urandom_range(3));
      end
   endtask

   task automatic test_mixed_traffic(input int gap, input int stall, input int n_items);
      int first_beat;
      int choice;
      gap_pct = gap;
      stall_pct = stall;
      first_beat = beats_sent;
      while (beats_sent - first_beat < n_items) begin
         set_registers($urandom_range(rows_ready), $urandom_range(8));
         repeat (10) begin
            choice = $urandom_range(99);
            if (choice < 65) begin
               issue_query($urandom_range(3));
            end else if (choice < 88) begin
               send_beat(CMD_CELL_WRITE,
                         ROW_IDX_W'($urandom_range(1) ? $urandom_range(rows_ready - 1)
                                                      : $urandom_range(ROWS - 1)),
                         ATTR_IDX_W'($urandom_range(ATTRS - 1)), pick_value(), pick_code(),
                         1'($urandom_range(1)));
            end else begin
               // A stray term that the next query picks up.
               send_beat(CMD_QUERY_TERM, ROW_IDX_W'($urandom_range(ROWS - 1)),
                         ATTR_IDX_W'($urandom_range(ATTRS - 1)), pick_value(), pick_code(),
                         1'b0);
            end
         end
      end
   endtask

   initial begin : response_monitor
      tally_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready) begin
            if (expected_tallies.size() == 0) begin
               error_count++;
               $display("%0t: result expected none actual count %0d hash %h supp %b",
                        $time, rsp_bus.match_count, rsp_bus.set_hash, rsp_bus.suppressed);
            end else begin
               want = expected_tallies.pop_front();
               compare_field("match_count", want.count, rsp_bus.match_count);
               compare_field("set_hash", want.hash, rsp_bus.set_hash);
               compare_field("suppressed", want.suppressed, rsp_bus.suppressed);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= CMD_CELL_WRITE;
      req_bus.row_index <= '0;
      req_bus.attr_index <= '0;
      req_bus.cell_or_term_value <= '0;
      req_bus.compare_code <= CMP_NONE;
      req_bus.last_term <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_RECORDS_IN_USE;
      csr_wdata <= '0;
      records_reg = '0;
      threshold_reg = '0;
      for (int a = 0; a < ATTRS; a++) begin
         bound_copy[a] = '0;
         code_copy[a] = CMP_NONE;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      fill_rows(0, 15);
      test_comparisons();
      test_register_sweep();
      test_mixed_traffic(0, 0, 55);
      test_mixed_traffic(51, 0, 55);
      test_mixed_traffic(0, 51, 55);
      test_mixed_traffic(32, 32, 55);
      wait_quiet();

      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   // Far beyond the slowest correct run, even with every beat a query under heavy stalls.
   initial begin
      #(10_000_000);
      $display("tb_top: errors");
      $finish;
   end

endmodule
